/* rtl/core/cwxc_pkg.sv */
// Package with the shared types and constants of the counter-weighted XOR word cipher.
`timescale 1ns / 1ps

package cwxc_pkg;

  localparam int unsigned DataW    = 32;
  localparam int unsigned KeyWords = 4;
  localparam int unsigned KeyIdxW  = $clog2(KeyWords);
  localparam int unsigned SaltMod  = 1024;
  localparam int unsigned SaltBits = $clog2(SaltMod);
  localparam int unsigned SaltBias = 255;
  localparam int unsigned ByteW    = 8;

  typedef logic [DataW-1:0] word_t;

  typedef enum logic [1:0] {
    ActStart = 2'd0,
    ActWord  = 2'd1,
    ActByte  = 2'd2
  } action_e;

endpackage

/* rtl/core/counter_weighted_xor_word_cipher_top.sv */
// Top level of the counter-weighted XOR word cipher: counter, key registers and two-stage pipe.
`timescale 1ns / 1ps

// The block takes one beat per cycle while in_ready_o is high and returns the result of a word
// or byte beat through the stage register in front of the single 32x32 multiplier and the
// output register behind it. A start beat reloads the position counter and yields no result;
// action code 3 is dropped. The key registers are written through the plain write port and
// must only be changed while no beat is in flight.
module counter_weighted_xor_word_cipher_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [31:0]         cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          action_i,
  input  logic [31:0]         data_in_i,
  input  logic [31:0]         message_size_i,
  input  logic [31:0]         salt_in_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [31:0]         data_out_o
);

  cwxc_pkg::word_t key_q [cwxc_pkg::KeyWords];
  cwxc_pkg::word_t cnt_q, cnt_d;

  logic            s1_valid_q, s1_valid_d;
  logic            s1_byte_q;
  cwxc_pkg::word_t s1_data_q;
  cwxc_pkg::word_t s1_cnt_q;

  logic            out_valid_q, out_valid_d;
  cwxc_pkg::word_t out_data_q, out_data_d;

  logic            in_fire;
  logic            is_data;
  logic            out_load;
  logic            s1_load;

  logic [cwxc_pkg::KeyIdxW-1:0] key_sel;
  cwxc_pkg::word_t              key_word;
  logic [cwxc_pkg::ByteW-1:0]   key_byte;
  cwxc_pkg::word_t              mul_a;
  cwxc_pkg::word_t              product;

  // Key registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < cwxc_pkg::KeyWords; k++) begin
        key_q[k] <= '0;
      end
    end else if (cfg_we_i) begin
      key_q[cfg_idx_i] <= cfg_wdata_i;
    end
  end

  // Handshake and stage enables.
  assign out_load   = !out_valid_q || out_ready_i;
  assign s1_load    = !s1_valid_q || out_load;
  assign in_ready_o = s1_load;
  assign in_fire    = in_valid_i && in_ready_o;
  assign is_data    = (action_i == cwxc_pkg::ActWord) || (action_i == cwxc_pkg::ActByte);

  // Position counter: loaded on a start beat, decremented ahead of each data beat.
  always_comb begin
    cnt_d = cnt_q;
    if (in_fire) begin
      case (action_i)
        cwxc_pkg::ActStart: begin
          cnt_d = message_size_i
                + cwxc_pkg::word_t'(salt_in_i[cwxc_pkg::SaltBits-1:0])
                + cwxc_pkg::word_t'(cwxc_pkg::SaltBias);
        end
        cwxc_pkg::ActWord, cwxc_pkg::ActByte: begin
          cnt_d = cnt_q - cwxc_pkg::word_t'(1);
        end
        default: begin
          cnt_d = cnt_q;
        end
      endcase
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (s1_load) begin
      s1_valid_d = in_fire && is_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      cnt_q      <= cnt_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load && in_fire) begin
      s1_byte_q <= (action_i == cwxc_pkg::ActByte);
      s1_data_q <= data_in_i;
      s1_cnt_q  <= cnt_d;
    end
  end

  // A byte beat picks the key word from counter bits 3:2 and the byte lane from bits 1:0;
  // a word beat picks the key word from bits 1:0.
  assign key_sel  = s1_byte_q ? s1_cnt_q[3:2] : s1_cnt_q[cwxc_pkg::KeyIdxW-1:0];
  assign key_word = key_q[key_sel];
  assign key_byte = key_word[s1_cnt_q[1:0]*cwxc_pkg::ByteW +: cwxc_pkg::ByteW];
  assign mul_a    = s1_byte_q ? cwxc_pkg::word_t'(key_byte) : key_word;
  assign product  = mul_a * s1_cnt_q;

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (out_load) begin
      out_valid_d = s1_valid_q;
      if (s1_byte_q) begin
        out_data_d = cwxc_pkg::word_t'(s1_data_q[cwxc_pkg::ByteW-1:0]
                                       ^ product[cwxc_pkg::ByteW-1:0]);
      end else begin
        out_data_d = s1_data_q ^ product;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign data_out_o  = out_data_q;

endmodule

/* rtl/core/cwxc_checker.sv */
// Port-level checker for the cipher top level, with its bind statement.
`timescale 1ns / 1ps

module cwxc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [1:0]  action_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] data_out_o
);

  logic data_beat;

  assign data_beat = in_valid_i && in_ready_o
                     && ((action_i == cwxc_pkg::ActWord) || (action_i == cwxc_pkg::ActByte));

  // A stalled result beat holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(data_out_o))
    else $error("result beat changed while stalled");

  // A new result always comes from a word or byte beat that passed through the stage register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(data_beat, 2))
    else $error("result appeared without a matching data beat");

  // The input side only stalls when the output is full and blocked.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled while output could drain");

  // A data beat taken while the output register is empty passes the stage register and shows up.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    data_beat && !out_valid_o |=> ##1 out_valid_o)
    else $error("data beat lost");

endmodule

bind counter_weighted_xor_word_cipher_top cwxc_checker u_cwxc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .action_i    (action_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .data_out_o  (data_out_o)
);

/* test/tb_top.sv */
// Self-checking testbench for the counter-weighted XOR word cipher top level.
`timescale 1ns / 1ps

module tb_top;

  localparam logic [1:0] RegKeyWord0 = 2'd0;
  localparam logic [1:0] RegKeyWord1 = 2'd1;
  localparam logic [1:0] RegKeyWord2 = 2'd2;
  localparam logic [1:0] RegKeyWord3 = 2'd3;
  localparam logic [1:0] ActUnused   = 2'd3;

  localparam int unsigned CycleLimit     = 200000;
  localparam int unsigned DrainCycles    = 4;
  localparam int unsigned PhaseBeats     = 125;
  localparam int unsigned LongHoldCycles = 300;

  typedef enum int {IdleNone, IdleSender, IdleReceiver, IdleBoth} idle_mode_e;

  typedef struct {
    logic [1:0]      action;
    cwxc_pkg::word_t data;
    cwxc_pkg::word_t size;
    cwxc_pkg::word_t salt;
  } beat_t;

  logic            clk          = 1'b0;
  logic            rst_n        = 1'b0;
  logic            cfg_we       = 1'b0;
  logic [1:0]      cfg_idx      = RegKeyWord0;
  cwxc_pkg::word_t cfg_wdata    = '0;
  logic            in_valid     = 1'b0;
  logic            in_ready;
  logic [1:0]      beat_action  = cwxc_pkg::ActStart;
  cwxc_pkg::word_t data_in      = '0;
  cwxc_pkg::word_t message_size = '0;
  cwxc_pkg::word_t salt_in      = '0;
  logic            out_valid;
  logic            out_ready    = 1'b0;
  cwxc_pkg::word_t data_out;

  // Predictor state: key registers and position counter as the block should hold them.
  cwxc_pkg::word_t key_model[cwxc_pkg::KeyWords];
  cwxc_pkg::word_t counter_model;
  cwxc_pkg::word_t expected_words[$];

  beat_t           pending_beats[$];
  beat_t           offered;
  bit              offer_busy = 1'b0;
  cwxc_pkg::word_t want_word;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_requests  = 0;
  int unsigned hold_served    = 0;
  int unsigned hold_left      = 0;
  int unsigned cycle_count    = 0;

  int unsigned errors          = 0;
  int unsigned results_checked = 0;
  int unsigned beats_taken     = 0;
  int unsigned starts_taken    = 0;
  int unsigned ignored_taken   = 0;

  counter_weighted_xor_word_cipher_top uut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .action_i       (beat_action),
    .data_in_i      (data_in),
    .message_size_i (message_size),
    .salt_in_i      (salt_in),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .data_out_o     (data_out)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic cipher_predict(input beat_t b);
    cwxc_pkg::word_t            prod;
    logic [3:0]                 kidx;
    logic [cwxc_pkg::ByteW-1:0] kbyte;
    case (b.action)
      cwxc_pkg::ActStart: begin
        counter_model = b.size + (b.salt % cwxc_pkg::SaltMod) + cwxc_pkg::SaltBias;
        starts_taken++;
      end
      cwxc_pkg::ActWord: begin
        counter_model = counter_model - 1'b1;
        prod = key_model[counter_model[cwxc_pkg::KeyIdxW-1:0]] * counter_model;
        expected_words.push_back(b.data ^ prod);
      end
      cwxc_pkg::ActByte: begin
        counter_model = counter_model - 1'b1;
        kidx = counter_model[3:0];
        kbyte = key_model[kidx[3:2]][kidx[1:0]*cwxc_pkg::ByteW +: cwxc_pkg::ByteW];
        prod = cwxc_pkg::word_t'(kbyte) * counter_model;
        expected_words.push_back({{(cwxc_pkg::DataW-cwxc_pkg::ByteW){1'b0}},
                                  b.data[cwxc_pkg::ByteW-1:0] ^ prod[cwxc_pkg::ByteW-1:0]});
      end
      default: begin
        ignored_taken++;
      end
    endcase
  endtask

  // Driver: the held beat is kept in offer_busy so the drain check never races the pop.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        cipher_predict(offered);
        beats_taken++;
        offer_busy = 1'b0;
      end
      if (!offer_busy && pending_beats.size() != 0 &&
          $urandom_range(99, 0) >= send_idle_pct) begin
        offered = pending_beats.pop_front();
        offer_busy = 1'b1;
        beat_action  <= offered.action;
        data_in      <= offered.data;
        message_size <= offered.size;
        salt_in      <= offered.salt;
      end
      in_valid <= offer_busy;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          errors++;
          $error("data_out: expected no result, got %h", data_out);
        end else begin
          want_word = expected_words.pop_front();
          results_checked++;
          if (data_out !== want_word) begin
            errors++;
            $error("data_out: expected %h, got %h", want_word, data_out);
          end
        end
      end
      if (hold_served != hold_requests) begin
        hold_served++;
        hold_left = LongHoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99, 0) >= recv_stall_pct);
      end
    end
  end

  task automatic queue_beat(input logic [1:0] act, input cwxc_pkg::word_t d,
                            input cwxc_pkg::word_t s, input cwxc_pkg::word_t sl);
    beat_t b;
    b.action = act;
    b.data   = d;
    b.size   = s;
    b.salt   = sl;
    pending_beats.push_back(b);
  endtask

  task automatic drain();
    do @(posedge clk);
    while (pending_beats.size() != 0 || offer_busy || expected_words.size() != 0);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_key(input logic [1:0] idx, input cwxc_pkg::word_t value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    key_model[idx] = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_keys(input cwxc_pkg::word_t k0, input cwxc_pkg::word_t k1,
                          input cwxc_pkg::word_t k2, input cwxc_pkg::word_t k3);
    write_key(RegKeyWord0, k0);
    write_key(RegKeyWord1, k1);
    write_key(RegKeyWord2, k2);
    write_key(RegKeyWord3, k3);
  endtask

  task automatic set_idle(input idle_mode_e mode);
    case (mode)
      IdleSender:   begin send_idle_pct = 85; recv_stall_pct = 0;  end
      IdleReceiver: begin send_idle_pct = 0;  recv_stall_pct = 85; end
      IdleBoth:     begin send_idle_pct = 8;  recv_stall_pct = 8;  end
      default:      begin send_idle_pct = 0;  recv_stall_pct = 0;  end
    endcase
  endtask

  // Mostly well-formed messages (start, words, tail bytes) with some loose beats mixed in.
  task automatic run_random_phase(input idle_mode_e mode, input bit long_hold);
    int unsigned queued;
    int unsigned nbytes;
    logic [1:0]  act;
    queued = 0;
    set_idle(mode);
    if (long_hold) hold_requests++;
    while (queued < PhaseBeats) begin
      if ($urandom_range(99, 0) < 80) begin
        nbytes = ($urandom_range(9, 0) == 0) ? $urandom_range(120, 0) : $urandom_range(24, 0);
        queue_beat(cwxc_pkg::ActStart, $urandom,
                   ($urandom_range(9, 0) == 0) ? $urandom : nbytes, $urandom);
        queued++;
        repeat (nbytes / 4) begin
          queue_beat(cwxc_pkg::ActWord, $urandom, $urandom, $urandom);
          queued++;
        end
        repeat (nbytes % 4) begin
          queue_beat(cwxc_pkg::ActByte, $urandom, $urandom, $urandom);
          queued++;
        end
      end else begin
        act = 2'($urandom_range(3, 0));
        queue_beat(act, $urandom, $urandom, $urandom);
        if (act != ActUnused) queued++;
      end
    end
    drain();
  endtask

  initial begin
    for (int k = 0; k < cwxc_pkg::KeyWords; k++) key_model[k] = '0;
    counter_model = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    set_idle(IdleNone);

    // A word ahead of any start runs off the reset counter of zero and wraps.
    queue_beat(cwxc_pkg::ActWord, 32'hFFFF_FFFF, '0, '0);
    drain();

    set_keys(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // The start below wraps the counter to zero, so the next word underflows it.
    queue_beat(cwxc_pkg::ActStart, '0, 32'hFFFF_FF01, '0);
    queue_beat(cwxc_pkg::ActWord, '0, '0, '0);
    queue_beat(cwxc_pkg::ActByte, 32'hFFFF_FFFF, '0, '0);
    queue_beat(cwxc_pkg::ActStart, 32'hFFFF_FFFF, '0, 32'hFFFF_FFFF);
    queue_beat(cwxc_pkg::ActWord, 32'hFFFF_FFFF, '0, '0);
    queue_beat(cwxc_pkg::ActWord, '0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_beat(cwxc_pkg::ActByte, 32'h0000_00FF, '0, '0);
    queue_beat(cwxc_pkg::ActByte, '0, '0, '0);
    queue_beat(ActUnused, $urandom, $urandom, $urandom);
    queue_beat(cwxc_pkg::ActWord, 32'hA5A5_A5A5, '0, '0);
    drain();

    set_keys(32'h8000_0001, 32'h0123_4567, 32'hFEDC_BA98, 32'h7FFF_FFFE);
    queue_beat(cwxc_pkg::ActStart, '0, 32'hFFFF_FFFF, 32'h0000_03FF);
    queue_beat(cwxc_pkg::ActByte, 32'h1234_5678, '0, '0);
    queue_beat(cwxc_pkg::ActByte, 32'hFFFF_FF00, '0, '0);
    queue_beat(cwxc_pkg::ActByte, '0, '0, '0);
    queue_beat(cwxc_pkg::ActByte, 32'h0000_00FF, '0, '0);
    queue_beat(cwxc_pkg::ActStart, '0, 32'd7, 32'h0000_0400);
    queue_beat(cwxc_pkg::ActWord, 32'hDEAD_BEEF, '0, '0);
    queue_beat(cwxc_pkg::ActByte, '0, '0, '0);
    queue_beat(cwxc_pkg::ActByte, 32'h0000_00FF, '0, '0);
    queue_beat(cwxc_pkg::ActByte, 32'h0000_005A, '0, '0);
    drain();

    set_keys($urandom, $urandom, $urandom, $urandom);
    run_random_phase(IdleNone, 1'b0);
    set_keys(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    run_random_phase(IdleSender, 1'b0);
    set_keys($urandom, $urandom, $urandom, $urandom);
    run_random_phase(IdleReceiver, 1'b0);
    set_keys('0, '0, '0, '0);
    run_random_phase(IdleBoth, 1'b0);
    // The long receiver hold fills the pipe while the sender keeps offering beats.
    set_keys($urandom, $urandom, $urandom, $urandom);
    run_random_phase(IdleNone, 1'b1);
    set_keys($urandom, $urandom, $urandom, $urandom);
    run_random_phase(IdleBoth, 1'b0);

    $display("Run covered %0d accepted beats (%0d starts, %0d unused codes), %0d results checked,",
             beats_taken, starts_taken, ignored_taken, results_checked);
    $display("over eight key settings, four idling modes and one long receiver hold.");
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
